/* rtl/bilinear_rgb_resize_defines.svh */
// Assertion macros shared by the bilinear resize checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BILINEAR_RGB_RESIZE_DEFINES_SVH
`define BILINEAR_RGB_RESIZE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BRR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bilinear_rgb_resize: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define BRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bilinear_rgb_resize: assertion failed");

`endif

/* rtl/brr_pkg.sv */
// Shared widths, codes and types for the bilinear RGB resizer.
// No dependencies.
package brr_pkg;

    localparam int SRC_W      = 8;              // source row/col index bits
    localparam int SRC_DIM    = 1 << SRC_W;     // 256
    localparam int TGT_W      = 10;             // target row/col index bits
    localparam int TGT_DIM    = 1 << TGT_W;     // 1024
    localparam int FRAC_W     = 16;
    localparam int RATIO_W    = SRC_W + FRAC_W; // 24
    localparam int POS_W      = TGT_W + RATIO_W;// 34
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int BANK_AW    = 2 * (SRC_W - 1);
    localparam int NUM_BANKS  = 4;
    localparam int CFG_W      = 11;
    localparam int WGT_W      = FRAC_W + 1;
    localparam int MIX_W      = FRAC_W + CH_W;          // 24
    localparam int SUM_W      = 2 * FRAC_W + CH_W;      // 40

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] REG_SRC_ROWS = 2'd0;
    localparam logic [1:0] REG_SRC_COLS = 2'd1;
    localparam logic [1:0] REG_TGT_ROWS = 2'd2;
    localparam logic [1:0] REG_TGT_COLS = 2'd3;

    typedef logic [PIX_W-1:0] t_pixel;

    // stage enables handed to the blend unit
    typedef struct packed {
        logic en_mix;
        logic en_out;
    } t_blend_ctl;

endpackage

/* rtl/brr_bank.sv */
// One bank of the frame store: one write port, one registered read port.
// Depends on brr_pkg.
module brr_bank (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [brr_pkg::BANK_AW-1:0] i_waddr,
    input  brr_pkg::t_pixel             i_wdata,
    input  logic                        i_re,
    input  logic [brr_pkg::BANK_AW-1:0] i_raddr,
    output brr_pkg::t_pixel             o_rdata
);

    brr_pkg::t_pixel r_mem [1 << brr_pkg::BANK_AW];
    brr_pkg::t_pixel r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/brr_div.sv */
// Restoring divider, one quotient bit per cycle, for a step ratio.
// Depends on brr_pkg. Restarts on every start request.
module brr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [brr_pkg::SRC_W-1:0]   i_num,
    input  logic [brr_pkg::TGT_W-1:0]   i_den,
    output logic                        o_busy,
    output logic [brr_pkg::RATIO_W-1:0] o_quo
);

    logic                        r_busy;
    logic [4:0]                  r_cnt;
    logic [brr_pkg::TGT_W-1:0]   r_rem;
    logic [brr_pkg::RATIO_W-1:0] r_quo;

    logic [brr_pkg::RATIO_W-1:0] dvd;
    logic [brr_pkg::TGT_W:0]     trial;
    logic                        q_bit;
    logic [brr_pkg::TGT_W-1:0]   n_rem;

    always_comb begin
        dvd   = {i_num, {brr_pkg::FRAC_W{1'b0}}};
        trial = {r_rem, dvd[5'(brr_pkg::RATIO_W - 1) - r_cnt]};
        q_bit = (trial >= {1'b0, i_den});
        n_rem = q_bit ? brr_pkg::TGT_W'(trial - {1'b0, i_den})
                      : brr_pkg::TGT_W'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quo  <= {r_quo[brr_pkg::RATIO_W-2:0], q_bit};
            r_cnt  <= r_cnt + 5'd1;
            if (r_cnt == 5'(brr_pkg::RATIO_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

/* rtl/brr_blend.sv */
// Merging stage: blends the four bank reads per channel in two registered steps.
// Depends on brr_pkg.
module brr_blend (
    input  logic                       i_clk,
    input  brr_pkg::t_blend_ctl        i_ctl,
    input  brr_pkg::t_pixel            i_p00,
    input  brr_pkg::t_pixel            i_p01,
    input  brr_pkg::t_pixel            i_p10,
    input  brr_pkg::t_pixel            i_p11,
    input  logic [brr_pkg::FRAC_W-1:0] i_fr,
    input  logic [brr_pkg::FRAC_W-1:0] i_fc,
    input  logic                       i_err,
    output brr_pkg::t_pixel            o_pixel,
    output logic                       o_err
);

    logic [brr_pkg::MIX_W-1:0]  r_left  [3];
    logic [brr_pkg::MIX_W-1:0]  r_right [3];
    logic [brr_pkg::FRAC_W-1:0] r_fc;
    logic                       r_err;
    brr_pkg::t_pixel            r_pixel;
    logic                       r_err_out;

    logic [brr_pkg::WGT_W-1:0]  wr0;
    logic [brr_pkg::WGT_W-1:0]  wc0;
    logic [brr_pkg::MIX_W-1:0]  n_left  [3];
    logic [brr_pkg::MIX_W-1:0]  n_right [3];
    logic [brr_pkg::SUM_W-1:0]  sum     [3];
    brr_pkg::t_pixel            n_pixel;

    always_comb begin
        wr0 = brr_pkg::WGT_W'(1 << brr_pkg::FRAC_W) - {1'b0, i_fr};
        wc0 = brr_pkg::WGT_W'(1 << brr_pkg::FRAC_W) - {1'b0, r_fc};
        for (int ch = 0; ch < 3; ch++) begin
            // channel 0 is red, held in the top byte
            n_left[ch] =
                brr_pkg::MIX_W'(i_fr)
                  * brr_pkg::MIX_W'(i_p10[brr_pkg::CH_W*(2-ch) +: brr_pkg::CH_W])
              + brr_pkg::MIX_W'(wr0)
                  * brr_pkg::MIX_W'(i_p00[brr_pkg::CH_W*(2-ch) +: brr_pkg::CH_W]);
            n_right[ch] =
                brr_pkg::MIX_W'(i_fr)
                  * brr_pkg::MIX_W'(i_p11[brr_pkg::CH_W*(2-ch) +: brr_pkg::CH_W])
              + brr_pkg::MIX_W'(wr0)
                  * brr_pkg::MIX_W'(i_p01[brr_pkg::CH_W*(2-ch) +: brr_pkg::CH_W]);
            sum[ch] = brr_pkg::SUM_W'(wc0) * brr_pkg::SUM_W'(r_left[ch])
                    + brr_pkg::SUM_W'(r_fc) * brr_pkg::SUM_W'(r_right[ch]);
            n_pixel[brr_pkg::CH_W*(2-ch) +: brr_pkg::CH_W] =
                r_err ? '0 : sum[ch][brr_pkg::SUM_W-1 -: brr_pkg::CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mix) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_fc    <= i_fc;
            r_err   <= i_err;
        end
        if (i_ctl.en_out) begin
            r_pixel   <= n_pixel;
            r_err_out <= r_err;
        end
    end

    assign o_pixel = r_pixel;
    assign o_err   = r_err_out;

endmodule

/* rtl/bilinear_rgb_resize.sv */
// Bilinear RGB resizer. Loads write one source pixel into a four-bank frame
// store (banked by row and column parity) and produce no result; queries
// return one blended pixel after four register stages (ratio multiply, bank
// read, row blend, column blend), at up to one request per clock. After reset
// and after each configuration write the two step ratios are recomputed by
// bit-serial dividers, during which s_axis_tready is low.
// Depends on brr_pkg, brr_bank, brr_div, brr_blend.
module bilinear_rgb_resize (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // pixel_row[9:0], pixel_col[19:10], red_in[27:20], green_in[35:28],
    // blue_in[43:36], zero fill
    input  logic [47:0]               s_axis_tdata,
    input  logic                      s_axis_tuser,   // cmd
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16]
    output logic [23:0]               m_axis_tdata,
    output logic                      m_axis_tuser,   // position_error
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_addr,
    input  logic [brr_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int SW = brr_pkg::SRC_W;
    localparam int TW = brr_pkg::TGT_W;

    logic [SW:0]   r_src_rows, r_src_cols;
    logic [TW:0]   r_tgt_rows, r_tgt_cols;

    logic [SW:0]   sr_eff, sc_eff;
    logic [TW:0]   tr_eff, tc_eff;
    logic [SW-1:0] sr_m1, sc_m1;
    logic [TW-1:0] tr_m1, tc_m1;

    logic                        row_busy, col_busy;
    logic [brr_pkg::RATIO_W-1:0] row_ratio, col_ratio;

    logic [TW-1:0]        in_row, in_col;
    brr_pkg::t_pixel      in_pix;
    logic                 s_acc, q_acc, l_acc, in_err;

    logic en1, en2, en3, en4;
    logic r_v1, r_v2, r_v3, r_v4;

    logic [brr_pkg::POS_W-1:0] r1_rpos, r1_cpos;
    logic                      r1_err;

    logic [brr_pkg::POS_W-brr_pkg::FRAC_W-1:0] r0_full, c0_full;
    logic [SW-1:0] r0, r1, c0, c1;

    logic [brr_pkg::FRAC_W-1:0] r2_fr, r2_fc;
    logic                       r2_err, r2_r0p, r2_r1p, r2_c0p, r2_c1p;

    brr_pkg::t_pixel bank_q [brr_pkg::NUM_BANKS];
    brr_pkg::t_blend_ctl blend_ctl;
    brr_pkg::t_pixel out_pix;
    logic            out_err;

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_rows <= (SW+1)'(brr_pkg::SRC_DIM);
            r_src_cols <= (SW+1)'(brr_pkg::SRC_DIM);
            r_tgt_rows <= (TW+1)'(brr_pkg::TGT_DIM / 2);
            r_tgt_cols <= (TW+1)'(brr_pkg::TGT_DIM / 2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                brr_pkg::REG_SRC_ROWS: r_src_rows <= i_cfg_data[SW:0];
                brr_pkg::REG_SRC_COLS: r_src_cols <= i_cfg_data[SW:0];
                brr_pkg::REG_TGT_ROWS: r_tgt_rows <= i_cfg_data;
                brr_pkg::REG_TGT_COLS: r_tgt_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        sr_eff = (r_src_rows < (SW+1)'(2)) ? (SW+1)'(2) :
                 (r_src_rows > (SW+1)'(brr_pkg::SRC_DIM)) ? (SW+1)'(brr_pkg::SRC_DIM) :
                 r_src_rows;
        sc_eff = (r_src_cols < (SW+1)'(2)) ? (SW+1)'(2) :
                 (r_src_cols > (SW+1)'(brr_pkg::SRC_DIM)) ? (SW+1)'(brr_pkg::SRC_DIM) :
                 r_src_cols;
        tr_eff = (r_tgt_rows < (TW+1)'(2)) ? (TW+1)'(2) :
                 (r_tgt_rows > (TW+1)'(brr_pkg::TGT_DIM)) ? (TW+1)'(brr_pkg::TGT_DIM) :
                 r_tgt_rows;
        tc_eff = (r_tgt_cols < (TW+1)'(2)) ? (TW+1)'(2) :
                 (r_tgt_cols > (TW+1)'(brr_pkg::TGT_DIM)) ? (TW+1)'(brr_pkg::TGT_DIM) :
                 r_tgt_cols;
        sr_m1 = SW'(sr_eff - (SW+1)'(1));
        sc_m1 = SW'(sc_eff - (SW+1)'(1));
        tr_m1 = TW'(tr_eff - (TW+1)'(1));
        tc_m1 = TW'(tc_eff - (TW+1)'(1));
    end

    brr_div u_div_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we),
        .i_num   (sr_m1),
        .i_den   (tr_m1),
        .o_busy  (row_busy),
        .o_quo   (row_ratio)
    );

    brr_div u_div_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we),
        .i_num   (sc_m1),
        .i_den   (tc_m1),
        .o_busy  (col_busy),
        .o_quo   (col_ratio)
    );

    // ---- stage enables: a stage moves when it is empty or its successor moves ----
    assign en4 = !r_v4 || m_axis_tready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign s_axis_tready = en1 && !row_busy && !col_busy;

    always_comb begin
        in_row = s_axis_tdata[TW-1:0];
        in_col = s_axis_tdata[2*TW-1:TW];
        in_pix = {s_axis_tdata[2*TW +: 8], s_axis_tdata[2*TW+8 +: 8],
                  s_axis_tdata[2*TW+16 +: 8]};
        s_acc  = s_axis_tvalid && s_axis_tready;
        q_acc  = s_acc && (s_axis_tuser == brr_pkg::CMD_QUERY);
        l_acc  = s_acc && (s_axis_tuser == brr_pkg::CMD_LOAD)
                 && (in_row[TW-1:SW] == '0) && (in_col[TW-1:SW] == '0);
        in_err = ({1'b0, in_row} >= tr_eff) || ({1'b0, in_col} >= tc_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= q_acc;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // ---- stage 1: position on the source grid ----
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_rpos <= brr_pkg::POS_W'(in_row) * brr_pkg::POS_W'(row_ratio);
            r1_cpos <= brr_pkg::POS_W'(in_col) * brr_pkg::POS_W'(col_ratio);
            r1_err  <= in_err;
        end
    end

    // ---- neighbours, clamped at the last row and column ----
    always_comb begin
        r0_full = r1_rpos[brr_pkg::POS_W-1:brr_pkg::FRAC_W];
        c0_full = r1_cpos[brr_pkg::POS_W-1:brr_pkg::FRAC_W];
        r0 = (r0_full > (brr_pkg::POS_W-brr_pkg::FRAC_W)'(sr_m1)) ? sr_m1 : r0_full[SW-1:0];
        c0 = (c0_full > (brr_pkg::POS_W-brr_pkg::FRAC_W)'(sc_m1)) ? sc_m1 : c0_full[SW-1:0];
        r1 = (r0 == sr_m1) ? r0 : r0 + SW'(1);
        c1 = (c0 == sc_m1) ? c0 : c0 + SW'(1);
    end

    // ---- stage 2: one read per bank ----
    for (genvar b = 0; b < brr_pkg::NUM_BANKS; b++) begin : g_bank
        logic            rp, cp;
        logic [SW-1:0]   rsel, csel;
        logic            we;

        assign rp   = 1'(b >> 1);
        assign cp   = 1'(b & 1);
        assign rsel = (r0[0] == rp) ? r0 : r1;
        assign csel = (c0[0] == cp) ? c0 : c1;
        assign we   = l_acc && (in_row[0] == rp) && (in_col[0] == cp);

        brr_bank u_bank (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr ({in_row[SW-1:1], in_col[SW-1:1]}),
            .i_wdata (in_pix),
            .i_re    (en2),
            .i_raddr ({rsel[SW-1:1], csel[SW-1:1]}),
            .o_rdata (bank_q[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_fr  <= r1_rpos[brr_pkg::FRAC_W-1:0];
            r2_fc  <= r1_cpos[brr_pkg::FRAC_W-1:0];
            r2_err <= r1_err;
            r2_r0p <= r0[0];
            r2_r1p <= r1[0];
            r2_c0p <= c0[0];
            r2_c1p <= c1[0];
        end
    end

    // ---- stages 3 and 4: blend ----
    assign blend_ctl.en_mix = en3;
    assign blend_ctl.en_out = en4;

    brr_blend u_blend (
        .i_clk   (i_clk),
        .i_ctl   (blend_ctl),
        .i_p00   (bank_q[{r2_r0p, r2_c0p}]),
        .i_p01   (bank_q[{r2_r0p, r2_c1p}]),
        .i_p10   (bank_q[{r2_r1p, r2_c0p}]),
        .i_p11   (bank_q[{r2_r1p, r2_c1p}]),
        .i_fr    (r2_fr),
        .i_fc    (r2_fc),
        .i_err   (r2_err),
        .o_pixel (out_pix),
        .o_err   (out_err)
    );

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {out_pix[7:0], out_pix[15:8], out_pix[23:16]};
    assign m_axis_tuser  = out_err;

endmodule

/* rtl/brr_checker.sv */
// Port-level checks for the bilinear RGB resizer, bound to the top level.
// Depends on bilinear_rgb_resize_defines.svh and bilinear_rgb_resize.
`include "bilinear_rgb_resize_defines.svh"

module brr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        i_cfg_we
);

    // a waiting result is not withdrawn
    `BRR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // a position error carries black channels
    `BRR_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 24'd0)

    // ratios are recomputed after a register write, so no request is taken next cycle
    `BRR_ASSERT_NEXT(a_cfg_stall, i_clk, i_rst_n, i_cfg_we, !s_axis_tready)

endmodule

bind bilinear_rgb_resize brr_checker u_brr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .i_cfg_we      (i_cfg_we)
);
